// ===== rtl/core/rlf_pkg.sv =====
package rlf_pkg;

  // Sizes fixed by the item fields
  localparam int VID_W            = 6;
  localparam int COLOR_W          = 6;
  localparam int NV_W             = 7;
  localparam int ROW_LIMIT        = 64;
  localparam int MAX_VERTICES_DEF = 64;
  localparam int NV_RESET         = 64;

  // Configuration port
  localparam int CFG_DATA_W = 32;
  localparam int CFG_ADDR_W = 2;
  localparam logic [CFG_ADDR_W-1:0] REG_NUM_VERTICES = 2'd0;

  // Request kinds
  localparam logic KIND_EDGE   = 1'b0;
  localparam logic KIND_FINISH = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_EDGE_RDA,
    ST_EDGE_WRA,
    ST_EDGE_WRB,
    ST_START,
    ST_CLASS,
    ST_SCAN,
    ST_COLOR,
    ST_NBR,
    ST_NBR_RD,
    ST_NBR_INC,
    ST_EMIT_RD,
    ST_EMIT_LD,
    ST_EMIT_HOLD
  } state_t;

  typedef enum logic [4:0] {
    OP_NONE,
    OP_ACCEPT,
    OP_EDGE_RDA,
    OP_EDGE_WRA,
    OP_EDGE_WRB,
    OP_START,
    OP_CLASS_INIT,
    OP_SCAN_INIT,
    OP_SCAN_STEP,
    OP_COLOR,
    OP_NBR,
    OP_NBR_RD,
    OP_NBR_INC,
    OP_NEXT_CLASS,
    OP_EMIT_INIT,
    OP_EMIT_RD,
    OP_EMIT_LD,
    OP_EMIT_NEXT,
    OP_CLEAR
  } op_t;

  typedef struct packed {
    op_t  op;
    logic in_ready;
  } cmd_t;

  typedef struct packed {
    logic edge_ok;
    logic uncolored_zero;
    logic unlinked_zero;
    logic scan_last;
    logic pend_zero;
    logic emit_done;
    logic out_taken;
  } stat_t;

endpackage

// ===== rtl/core/rlf_if.sv =====
interface rlf_in_if;
  logic       valid;
  logic       ready;
  logic       kind;
  logic [5:0] edge_from;
  logic [5:0] edge_to;

  modport source (output valid, output kind, output edge_from, output edge_to, input ready);
  modport sink (input valid, input kind, input edge_from, input edge_to, output ready);
endinterface

interface rlf_out_if;
  logic       valid;
  logic       ready;
  logic [5:0] vertex_index;
  logic [5:0] color;
  logic       last;

  modport source (output valid, output vertex_index, output color, output last, input ready);
  modport sink (input valid, input vertex_index, input color, input last, output ready);
endinterface

// ===== rtl/core/rlf_graph_coloring_unit.sv =====
// Edge request: read-modify-write of two rows (states EDGE_RDA, EDGE_WRA, EDGE_WRB),
//   then back to ready; a self loop or an endpoint beyond the row count ends after EDGE_RDA.
// Finish request: each pick is a lane scan of the link counts over ROWS lanes, then every
//   vertex joining the frontier adds to its neighbors' counts; ROWS = min(MAX_VERTICES, 64).
// Each result is read from the color store, loaded and held until the output takes it.
// Reset (rst_n, synchronous): matrix row valid bits cleared at once, no clearing pass;
//   num_vertices returns to 64.
module rlf_graph_coloring_unit #(
  parameter int MAX_VERTICES = rlf_pkg::MAX_VERTICES_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  rlf_in_if.sink                            in_ch,
  rlf_out_if.source                         out_ch,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [rlf_pkg::CFG_ADDR_W-1:0]    paddr,
  input  logic [rlf_pkg::CFG_DATA_W-1:0]    pwdata,
  output logic [rlf_pkg::CFG_DATA_W-1:0]    prdata,
  output logic                              pready
);
  import rlf_pkg::*;

  logic [NV_W-1:0] num_vertices_r;
  cmd_t            cmd;
  stat_t           stat;

  assign pready = 1'b1;

  // configuration register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      num_vertices_r <= NV_W'(NV_RESET);
    end else if (psel && penable && pwrite && pready && (paddr == REG_NUM_VERTICES)) begin
      num_vertices_r <= pwdata[NV_W-1:0];
    end
  end

  assign prdata = (paddr == REG_NUM_VERTICES)
                ? {{(CFG_DATA_W-NV_W){1'b0}}, num_vertices_r} : '0;

  assign in_ch.ready = cmd.in_ready;

  rlf_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_kind  (in_ch.kind),
    .stat     (stat),
    .cmd      (cmd)
  );

  rlf_dpath #(
    .MAX_VERTICES (MAX_VERTICES)
  ) u_dpath (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .stat             (stat),
    .num_vertices     (num_vertices_r),
    .in_edge_from     (in_ch.edge_from),
    .in_edge_to       (in_ch.edge_to),
    .out_ready        (out_ch.ready),
    .out_valid        (out_ch.valid),
    .out_vertex_index (out_ch.vertex_index),
    .out_color        (out_ch.color),
    .out_last         (out_ch.last)
  );

endmodule

// ===== rtl/core/rlf_ctrl.sv =====
module rlf_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  input  logic          in_kind,
  input  rlf_pkg::stat_t stat,
  output rlf_pkg::cmd_t  cmd
);
  import rlf_pkg::*;

  state_t state_r;
  state_t state_nxt;

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state and commands
  always_comb begin
    state_nxt    = state_r;
    cmd.op       = OP_NONE;
    cmd.in_ready = 1'b0;
    case (state_r)
      ST_IDLE: begin
        cmd.in_ready = 1'b1;
        if (in_valid) begin
          cmd.op    = OP_ACCEPT;
          state_nxt = (in_kind == KIND_FINISH) ? ST_START : ST_EDGE_RDA;
        end
      end
      ST_EDGE_RDA: begin
        cmd.op    = OP_EDGE_RDA;
        state_nxt = stat.edge_ok ? ST_EDGE_WRA : ST_IDLE;
      end
      ST_EDGE_WRA: begin
        cmd.op    = OP_EDGE_WRA;
        state_nxt = ST_EDGE_WRB;
      end
      ST_EDGE_WRB: begin
        cmd.op    = OP_EDGE_WRB;
        state_nxt = ST_IDLE;
      end
      ST_START: begin
        cmd.op    = OP_START;
        state_nxt = ST_CLASS;
      end
      ST_CLASS: begin
        if (stat.uncolored_zero) begin
          cmd.op    = OP_EMIT_INIT;
          state_nxt = ST_EMIT_RD;
        end else begin
          cmd.op    = OP_CLASS_INIT;
          state_nxt = ST_SCAN;
        end
      end
      ST_SCAN: begin
        cmd.op = OP_SCAN_STEP;
        if (stat.scan_last) state_nxt = ST_COLOR;
      end
      ST_COLOR: begin
        cmd.op    = OP_COLOR;
        state_nxt = ST_NBR;
      end
      ST_NBR: begin
        cmd.op    = OP_NBR;
        state_nxt = ST_NBR_RD;
      end
      ST_NBR_RD: begin
        if (!stat.pend_zero) begin
          cmd.op    = OP_NBR_RD;
          state_nxt = ST_NBR_INC;
        end else if (stat.unlinked_zero) begin
          cmd.op    = OP_NEXT_CLASS;
          state_nxt = ST_CLASS;
        end else begin
          cmd.op    = OP_SCAN_INIT;
          state_nxt = ST_SCAN;
        end
      end
      ST_NBR_INC: begin
        cmd.op    = OP_NBR_INC;
        state_nxt = ST_NBR_RD;
      end
      ST_EMIT_RD: begin
        if (stat.emit_done) begin
          cmd.op    = OP_CLEAR;
          state_nxt = ST_IDLE;
        end else begin
          cmd.op    = OP_EMIT_RD;
          state_nxt = ST_EMIT_LD;
        end
      end
      ST_EMIT_LD: begin
        cmd.op    = OP_EMIT_LD;
        state_nxt = ST_EMIT_HOLD;
      end
      ST_EMIT_HOLD: begin
        if (stat.out_taken) begin
          cmd.op    = OP_EMIT_NEXT;
          state_nxt = ST_EMIT_RD;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

// ===== rtl/core/rlf_dpath.sv =====
module rlf_dpath #(
  parameter int MAX_VERTICES = rlf_pkg::MAX_VERTICES_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  rlf_pkg::cmd_t                cmd,
  output rlf_pkg::stat_t               stat,
  input  logic [rlf_pkg::NV_W-1:0]     num_vertices,
  input  logic [rlf_pkg::VID_W-1:0]    in_edge_from,
  input  logic [rlf_pkg::VID_W-1:0]    in_edge_to,
  input  logic                         out_ready,
  output logic                         out_valid,
  output logic [rlf_pkg::VID_W-1:0]    out_vertex_index,
  output logic [rlf_pkg::COLOR_W-1:0]  out_color,
  output logic                         out_last
);
  import rlf_pkg::*;

  localparam int ROWS = (MAX_VERTICES < ROW_LIMIT) ? MAX_VERTICES : ROW_LIMIT;
  localparam int RW   = $clog2(ROWS);
  localparam int CW   = $clog2(ROWS);
  localparam logic [ROWS-1:0] BIT0 = {{(ROWS-1){1'b0}}, 1'b1};

  // adjacency matrix and its row valid bits
  logic [ROWS-1:0]    adj_mem [ROWS];
  logic [ROWS-1:0]    row_vld_r;
  logic [ROWS-1:0]    adj_rd_r;
  logic               rd_vld_r;
  logic               adj_we;
  logic               adj_re;
  logic [RW-1:0]      adj_waddr;
  logic [RW-1:0]      adj_raddr;
  logic [ROWS-1:0]    adj_wdata;

  // color store
  logic [COLOR_W-1:0] color_mem [ROWS];
  logic [COLOR_W-1:0] color_rd_r;

  logic [VID_W-1:0]   edge_a_r;
  logic [VID_W-1:0]   edge_b_r;
  logic [ROWS-1:0]    uncolored_r;
  logic [ROWS-1:0]    unlinked_r;
  logic [ROWS-1:0]    pend_r;
  logic [ROWS-1:0]    scan_unl_r;
  logic [CW-1:0]      cnt_r [ROWS];
  logic [RW-1:0]      scan_idx_r;
  logic [RW-1:0]      best_r;
  logic [CW-1:0]      best_cnt_r;
  logic               found_r;
  logic [COLOR_W-1:0] class_r;
  logic [NV_W-1:0]    emit_idx_r;
  logic               out_valid_r;
  logic [VID_W-1:0]   out_vid_r;
  logic [COLOR_W-1:0] out_color_r;
  logic               out_last_r;

  logic [NV_W-1:0]    n_eff;
  logic [ROWS-1:0]    mask;
  logic [ROWS-1:0]    row;
  logic [ROWS-1:0]    best_bit;
  logic [ROWS-1:0]    nbr_new;
  logic [RW-1:0]      a_idx;
  logic [RW-1:0]      b_idx;
  logic [RW-1:0]      ff_idx;
  logic               edge_ok;
  logic               take;

  // effective vertex count and its mask
  always_comb begin
    n_eff = (num_vertices > NV_W'(ROWS)) ? NV_W'(ROWS) : num_vertices;
    for (int i = 0; i < ROWS; i++) begin
      mask[i] = (NV_W'(i) < n_eff);
    end
  end

  assign row      = rd_vld_r ? adj_rd_r : '0;
  assign a_idx    = edge_a_r[RW-1:0];
  assign b_idx    = edge_b_r[RW-1:0];
  assign best_bit = BIT0 << best_r;
  assign nbr_new  = row & mask & uncolored_r & unlinked_r;
  assign edge_ok  = (edge_a_r != edge_b_r)
                 && ({1'b0, edge_a_r} < NV_W'(ROWS))
                 && ({1'b0, edge_b_r} < NV_W'(ROWS));
  assign take     = scan_unl_r[0] && (!found_r || (cnt_r[0] > best_cnt_r));

  // lowest pending frontier vertex
  always_comb begin
    ff_idx = '0;
    for (int i = ROWS - 1; i >= 0; i--) begin
      if (pend_r[i]) ff_idx = RW'(i);
    end
  end

  // matrix port selection
  always_comb begin
    adj_we    = 1'b0;
    adj_re    = 1'b0;
    adj_waddr = a_idx;
    adj_raddr = a_idx;
    adj_wdata = row | (BIT0 << b_idx);
    case (cmd.op)
      OP_EDGE_RDA: begin
        adj_re = 1'b1;
      end
      OP_EDGE_WRA: begin
        adj_we    = 1'b1;
        adj_re    = 1'b1;
        adj_raddr = b_idx;
      end
      OP_EDGE_WRB: begin
        adj_we    = 1'b1;
        adj_waddr = b_idx;
        adj_wdata = row | (BIT0 << a_idx);
      end
      OP_COLOR: begin
        adj_re    = 1'b1;
        adj_raddr = best_r;
      end
      OP_NBR_RD: begin
        adj_re    = 1'b1;
        adj_raddr = ff_idx;
      end
      default: begin
      end
    endcase
  end

  // adjacency memory
  always_ff @(posedge clk) begin
    if (adj_we) adj_mem[adj_waddr] <= adj_wdata;
    if (adj_re) begin
      adj_rd_r <= adj_mem[adj_raddr];
      rd_vld_r <= row_vld_r[adj_raddr];
    end
  end

  // color memory
  always_ff @(posedge clk) begin
    if (cmd.op == OP_COLOR) color_mem[best_r] <= class_r;
    if (cmd.op == OP_EMIT_RD) color_rd_r <= color_mem[emit_idx_r[RW-1:0]];
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_vld_r   <= '0;
      uncolored_r <= '0;
      unlinked_r  <= '0;
      pend_r      <= '0;
      class_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      case (cmd.op)
        OP_EDGE_WRA:   row_vld_r[a_idx] <= 1'b1;
        OP_EDGE_WRB:   row_vld_r[b_idx] <= 1'b1;
        OP_CLEAR:      row_vld_r <= '0;
        OP_START: begin
          uncolored_r <= mask;
          class_r     <= '0;
        end
        OP_CLASS_INIT: unlinked_r <= uncolored_r;
        OP_COLOR: begin
          uncolored_r <= uncolored_r & ~best_bit;
          unlinked_r  <= unlinked_r & ~best_bit;
        end
        OP_NBR: begin
          pend_r     <= nbr_new;
          unlinked_r <= unlinked_r & ~nbr_new;
        end
        OP_NBR_RD:     pend_r[ff_idx] <= 1'b0;
        OP_NEXT_CLASS: class_r <= class_r + COLOR_W'(1);
        OP_EMIT_LD:    out_valid_r <= 1'b1;
        OP_EMIT_NEXT:  out_valid_r <= 1'b0;
        default: begin
        end
      endcase
    end
  end

  // scan lanes, link counts and result payload
  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_ACCEPT: begin
        edge_a_r <= in_edge_from;
        edge_b_r <= in_edge_to;
      end
      OP_CLASS_INIT: begin
        for (int i = 0; i < ROWS; i++) cnt_r[i] <= '0;
        scan_unl_r <= uncolored_r;
        scan_idx_r <= '0;
        found_r    <= 1'b0;
      end
      OP_SCAN_INIT: begin
        scan_unl_r <= unlinked_r;
        scan_idx_r <= '0;
        found_r    <= 1'b0;
      end
      OP_SCAN_STEP: begin
        // rotate the counts past lane zero; one full turn restores them
        if (take) begin
          found_r    <= 1'b1;
          best_r     <= scan_idx_r;
          best_cnt_r <= cnt_r[0];
        end
        for (int i = 0; i < ROWS; i++) cnt_r[i] <= cnt_r[(i + 1) % ROWS];
        scan_unl_r <= scan_unl_r >> 1;
        scan_idx_r <= scan_idx_r + RW'(1);
      end
      OP_NBR_INC: begin
        for (int w = 0; w < ROWS; w++) begin
          if (row[w] && mask[w]) cnt_r[w] <= cnt_r[w] + CW'(1);
        end
      end
      OP_EMIT_INIT: emit_idx_r <= '0;
      OP_EMIT_LD: begin
        out_vid_r   <= emit_idx_r[VID_W-1:0];
        out_color_r <= color_rd_r;
        out_last_r  <= ((emit_idx_r + NV_W'(1)) == n_eff);
      end
      OP_EMIT_NEXT: emit_idx_r <= emit_idx_r + NV_W'(1);
      default: begin
      end
    endcase
  end

  assign stat.edge_ok        = edge_ok;
  assign stat.uncolored_zero = (uncolored_r == '0);
  assign stat.unlinked_zero  = (unlinked_r == '0);
  assign stat.scan_last      = (scan_idx_r == RW'(ROWS - 1));
  assign stat.pend_zero      = (pend_r == '0);
  assign stat.emit_done      = (emit_idx_r == n_eff);
  assign stat.out_taken      = out_valid_r & out_ready;

  assign out_valid        = out_valid_r;
  assign out_vertex_index = out_vid_r;
  assign out_color        = out_color_r;
  assign out_last         = out_last_r;

`ifndef SYNTHESIS
  a_unlinked_subset: assert property (@(posedge clk) disable iff (!rst_n)
    (unlinked_r & ~uncolored_r) == '0)
    else $error("unlinked vertex that is already colored");

  a_pend_disjoint: assert property (@(posedge clk) disable iff (!rst_n)
    (pend_r & unlinked_r) == '0)
    else $error("frontier vertex still marked unlinked");

  a_out_index: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (emit_idx_r < n_eff))
    else $error("result for a vertex beyond the count");
`endif

endmodule

// ===== tb/sv/tb_rlf_coloring_checker.sv =====
`timescale 1ns / 100ps

// Watches the request and result channels and the register port, keeps its own
// copy of the graph, colors it on every finish request and checks the results.
module tb_rlf_coloring_checker (
  input  logic                           clk,
  input  logic                           rst_n,
  rlf_in_if                              in_mon,
  rlf_out_if                             out_mon,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic                           pready,
  input  logic [rlf_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [rlf_pkg::CFG_DATA_W-1:0] pwdata,
  output int                             fail_count,
  output int                             colors_pending,
  output int                             colors_seen
);
  import rlf_pkg::*;

  typedef struct {
    logic [VID_W-1:0]   vertex;
    logic [COLOR_W-1:0] color;
    logic               last;
  } vertex_color_t;

  logic [63:0]        adj_model [64];
  logic [5:0]         links [64];
  logic [COLOR_W-1:0] class_of [64];
  logic [NV_W-1:0]    vertex_count;
  vertex_color_t      color_q [$];

  // Add an undirected edge; self loops are dropped
  function automatic void add_edge(logic [5:0] a, logic [5:0] b);
    if (a != b) begin
      adj_model[a][b] = 1'b1;
      adj_model[b][a] = 1'b1;
    end
  endfunction

  // Recursive largest first over the first n vertices, then queue one color per vertex
  function automatic void color_graph();
    int          n;
    int          best;
    bit          found;
    logic [5:0]  best_links;
    logic [63:0] mask;
    logic [63:0] uncolored;
    logic [63:0] unlinked;
    logic [63:0] nbrs;
    logic [5:0]  cls;
    vertex_color_t vc;
    n = (vertex_count > 64) ? 64 : int'(vertex_count);
    mask = (n >= 64) ? '1 : ((64'd1 << n) - 64'd1);
    uncolored = mask;
    cls = '0;
    while (uncolored != 0) begin
      unlinked = uncolored;
      for (int i = 0; i < n; i++) links[i] = '0;
      while (unlinked != 0) begin
        found = 1'b0;
        best = 0;
        best_links = '0;
        for (int i = 0; i < n; i++) begin
          if (unlinked[i] && (!found || links[i] > best_links)) begin
            found = 1'b1;
            best = i;
            best_links = links[i];
          end
        end
        class_of[best] = cls;
        uncolored[best] = 1'b0;
        unlinked[best] = 1'b0;
        nbrs = adj_model[best] & mask & uncolored;
        // each neighbor joins the frontier once
        for (int u = 0; u < n; u++) begin
          if (nbrs[u] && unlinked[u]) begin
            unlinked[u] = 1'b0;
            for (int w = 0; w < n; w++)
              if (adj_model[u][w]) links[w] = links[w] + 6'd1;
          end
        end
      end
      cls = cls + 6'd1;
    end
    for (int i = 0; i < n; i++) begin
      vc.vertex = i[5:0];
      vc.color = class_of[i];
      vc.last = (i == n - 1);
      color_q.push_back(vc);
    end
    for (int r = 0; r < 64; r++) adj_model[r] = '0;
  endfunction

  always @(posedge clk) begin
    vertex_color_t exp_vc;
    if (!rst_n) begin
      for (int r = 0; r < 64; r++) adj_model[r] = '0;
      vertex_count = NV_W'(NV_RESET);
      color_q.delete();
      fail_count = 0;
      colors_seen = 0;
    end else begin
      // register writes
      if (psel && penable && pwrite && pready && paddr == REG_NUM_VERTICES)
        vertex_count = pwdata[NV_W-1:0];
      // accepted request
      if (in_mon.valid && in_mon.ready) begin
        if (in_mon.kind == KIND_EDGE) add_edge(in_mon.edge_from, in_mon.edge_to);
        else color_graph();
      end
      // accepted result
      if (out_mon.valid && out_mon.ready) begin
        colors_seen++;
        if (color_q.size() == 0) begin
          fail_count++;
          $display("%0t: unexpected result vertex=%0d color=%0d last=%0d", $time,
                   out_mon.vertex_index, out_mon.color, out_mon.last);
        end else begin
          exp_vc = color_q.pop_front();
          if (out_mon.vertex_index !== exp_vc.vertex) begin
            fail_count++;
            $display("%0t: vertex_index expected %0d actual %0d", $time, exp_vc.vertex,
                     out_mon.vertex_index);
          end
          if (out_mon.color !== exp_vc.color) begin
            fail_count++;
            $display("%0t: color of vertex %0d expected %0d actual %0d", $time,
                     exp_vc.vertex, exp_vc.color, out_mon.color);
          end
          if (out_mon.last !== exp_vc.last) begin
            fail_count++;
            $display("%0t: last of vertex %0d expected %0d actual %0d", $time,
                     exp_vc.vertex, exp_vc.last, out_mon.last);
          end
        end
      end
    end
    colors_pending = color_q.size();
  end

endmodule

// ===== tb/sv/tb_rlf_graph_coloring_unit.sv =====
`timescale 1ns / 100ps

module tb_rlf_graph_coloring_unit;
  import rlf_pkg::*;

  localparam int CYCLE_LIMIT = 10000000;
  localparam int ITEM_TARGET = 460;

  logic clk;
  logic rst_n;
  logic psel;
  logic penable;
  logic pwrite;
  logic [CFG_ADDR_W-1:0] paddr;
  logic [CFG_DATA_W-1:0] pwdata;
  logic [CFG_DATA_W-1:0] prdata;
  logic pready;
  int   fail_count;
  int   colors_pending;
  int   colors_seen;
  int   cycles;
  int   items_sent;
  int   finishes_sent;
  int   burst_left;
  bit   long_hold_done;

  rlf_in_if  in_ch ();
  rlf_out_if out_ch ();

  rlf_graph_coloring_unit u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .pready (pready)
  );

  tb_rlf_coloring_checker u_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_mon        (in_ch),
    .out_mon       (out_ch),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .pready        (pready),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .fail_count    (fail_count),
    .colors_pending(colors_pending),
    .colors_seen   (colors_seen)
  );

  initial clk = 1'b0;
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Watchdog
  initial cycles = 0;
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("rlf_graph_coloring_unit verification failed");
      $finish;
    end
  end

  // Result side: stall mode redrawn at random from three, plus one long hold-off
  initial begin
    int mode;
    int hold;
    out_ch.ready = 1'b0;
    long_hold_done = 1'b0;
    mode = 0;
    forever begin
      @(negedge clk);
      if (cycles % 64 == 0) mode = $urandom_range(0, 2);
      // hold off while a request waits at the input so the block stalls it
      if (!long_hold_done && out_ch.valid && in_ch.valid && cycles > 3000) begin
        long_hold_done = 1'b1;
        out_ch.ready = 1'b0;
        for (hold = 0; hold < 1500; hold++) @(negedge clk);
      end
      case (mode)
        0: out_ch.ready = 1'b1;
        1: out_ch.ready = 1'($urandom_range(0, 1));
        default: out_ch.ready = ($urandom_range(0, 3) == 0);
      endcase
    end
  end

  // One request; entered and left at a falling edge, valid left high
  task automatic send_request(logic kind, logic [5:0] a, logic [5:0] b);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      in_ch.valid = 1'b0;
      repeat (gap) @(negedge clk);
      burst_left = $urandom_range(1, 12);
    end
    burst_left--;
    in_ch.valid = 1'b1;
    in_ch.kind = kind;
    in_ch.edge_from = a;
    in_ch.edge_to = b;
    do @(posedge clk); while (!in_ch.ready);
    @(negedge clk);
    items_sent++;
    if (kind == KIND_FINISH) finishes_sent++;
  endtask

  // Let the block go quiet: no results owed and no edge update in flight
  task automatic wait_idle();
    in_ch.valid = 1'b0;
    while (colors_pending != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  task automatic write_vertex_count(logic [NV_W-1:0] count);
    psel = 1'b1;
    penable = 1'b0;
    pwrite = 1'b1;
    paddr = REG_NUM_VERTICES;
    pwdata = CFG_DATA_W'(count);
    @(negedge clk);
    penable = 1'b1;
    @(negedge clk);
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
  endtask

  initial begin
    int nv;
    int span;
    int n_edges;
    logic [5:0] a;
    logic [5:0] b;
    rst_n = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    in_ch.valid = 1'b0;
    in_ch.kind = KIND_EDGE;
    in_ch.edge_from = '0;
    in_ch.edge_to = '0;
    items_sent = 0;
    finishes_sent = 0;
    burst_left = 0;
    repeat (9) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // Directed: reset count of 64, extreme endpoints, duplicates, self loop
    send_request(KIND_EDGE, 6'd0, 6'd63);
    send_request(KIND_EDGE, 6'd63, 6'd0);
    send_request(KIND_EDGE, 6'd5, 6'd5);
    send_request(KIND_EDGE, 6'd0, 6'd1);
    send_request(KIND_EDGE, 6'd1, 6'd2);
    send_request(KIND_EDGE, 6'd2, 6'd0);
    send_request(KIND_FINISH, 6'd0, 6'd0);
    wait_idle();
    // zero vertices: nothing emitted, matrix still cleared
    write_vertex_count(7'd0);
    send_request(KIND_EDGE, 6'd3, 6'd4);
    send_request(KIND_FINISH, 6'd63, 6'd63);
    wait_idle();
    // single vertex with an edge beyond the count
    write_vertex_count(7'd1);
    send_request(KIND_EDGE, 6'd0, 6'd1);
    send_request(KIND_FINISH, 6'd0, 6'd0);
    wait_idle();
    // edge touching a vertex above the count stays out of the coloring
    write_vertex_count(7'd3);
    send_request(KIND_EDGE, 6'd2, 6'd40);
    send_request(KIND_EDGE, 6'd0, 6'd1);
    send_request(KIND_EDGE, 6'd1, 6'd2);
    send_request(KIND_FINISH, 6'd0, 6'd0);
    wait_idle();
    // count above the row limit saturates
    write_vertex_count(7'd127);
    send_request(KIND_EDGE, 6'd62, 6'd63);
    send_request(KIND_FINISH, 6'd0, 6'd0);
    wait_idle();
    nv = 127;

    // Random graphs; the count changes only on an idle block
    while (items_sent < ITEM_TARGET) begin
      if ($urandom_range(0, 1) == 0) begin
        wait_idle();
        case ($urandom_range(0, 15))
          0, 1: nv = 64;
          2: nv = 127;
          3: nv = 0;
          4: nv = $urandom_range(65, 126);
          5: nv = $urandom_range(13, 63);
          default: nv = $urandom_range(1, 12);
        endcase
        write_vertex_count(nv[NV_W-1:0]);
      end
      span = (nv < 2) ? 64 : ((nv > 64) ? 64 : nv);
      n_edges = $urandom_range(0, 3) == 0 ? $urandom_range(0, 4) : $urandom_range(5, 35);
      for (int e = 0; e < n_edges; e++) begin
        case ($urandom_range(0, 19))
          0, 1: begin
            a = 6'($urandom_range(0, 63));
            b = 6'($urandom_range(0, 63));
          end
          2: begin
            a = 6'($urandom_range(0, 63));
            b = a;
          end
          default: begin
            a = 6'($urandom_range(0, span - 1));
            b = 6'($urandom_range(0, span - 1));
          end
        endcase
        send_request(KIND_EDGE, a, b);
      end
      a = 6'($urandom_range(0, 63));
      b = 6'($urandom_range(0, 63));
      send_request(KIND_FINISH, a, b);
    end

    wait_idle();
    $display("Sent %0d requests including %0d finish requests; checked %0d vertex colors.",
             items_sent, finishes_sent, colors_seen);
    $display("Vertex counts spanned zero, one, small, full and saturated settings.");
    if (fail_count == 0 && colors_pending == 0) begin
      $display("rlf_graph_coloring_unit verification clean");
    end else begin
      $display("rlf_graph_coloring_unit verification failed");
    end
    $finish;
  end

endmodule
